// ----- rtl/core/lfps_pkg.sv -----
package lfps_pkg;

	// Field widths
	localparam int SENSOR_W = 8;
	localparam int ELAPSED_W = 16;
	localparam int GAIN_W = 32;
	localparam int SPEED_W = 15;
	localparam int PID_W = 15;
	localparam int DRIVE_W = 16;
	localparam int ERR_W = 8;
	localparam int INTEG_W = 32;

	// Packed stream widths
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 48;

	// Configuration bus
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	// Fixed-point limits
	localparam int I_LIMIT_Q16 = 13107;     // 0.2 in Q.16
	localparam int PID_LIMIT_Q16 = 32768;   // 0.5 in Q.16
	localparam int ONE_Q14 = 16384;         // 1.0 in Q2.14
	localparam int FRAC_Q14 = 14;

	// Derivative divider: magnitude of the 41-bit numerator
	localparam int DIV_STEPS = 40;
	localparam int DIV_CNT_W = 6;

	// Accumulator for P + I + D
	localparam int ACC_W = 43;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN  = 2'd0,
		REG_INTEG_GAIN = 2'd1,
		REG_DERIV_GAIN = 2'd2,
		REG_SPEED_MULT = 2'd3
	} reg_idx_t;

	typedef enum logic [11:0] {
		ST_IDLE     = 12'b0000_0000_0001,
		ST_MUL_P    = 12'b0000_0000_0010,
		ST_MUL_E    = 12'b0000_0000_0100,
		ST_SUM_I    = 12'b0000_0000_1000,
		ST_MUL_I    = 12'b0000_0001_0000,
		ST_MUL_D    = 12'b0000_0010_0000,
		ST_DIV_INIT = 12'b0000_0100_0000,
		ST_DIV      = 12'b0000_1000_0000,
		ST_PID      = 12'b0001_0000_0000,
		ST_MIX_L    = 12'b0010_0000_0000,
		ST_MIX_R    = 12'b0100_0000_0000,
		ST_DONE     = 12'b1000_0000_0000
	} state_t;

endpackage

// ----- rtl/core/line_follow_pid_steering_top.sv -----
// Line-following PID steering. Each input word carries the line sensor bits (tdata[7:0]) and the
// milliseconds since the last sample (tdata[23:8]); each output word carries the steering value
// and the left/right drives in Q2.14. One word is worked on at a time and s_tready is high only
// while the block is idle. A sample with zero elapsed time goes straight to the mix steps and
// leaves the PID state alone; any other sample runs the restoring divider, which produces one
// quotient bit per cycle for the derivative term, and makes six passes through the single shared
// 32x32 signed multiplier with the accumulate/clamp steps around it. A finished result waits in
// the output register while the next sample is accepted. Gains and speed are written over the cfg
// port (index 0 prop_gain, 1 integ_gain, 2 deriv_gain, 3 speed_multiplier); the user must write
// them only while the block is idle; the block itself does not enforce this.
module line_follow_pid_steering_top #(
	parameter int SENSOR_COUNT = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lfps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lfps_pkg::CFG_DATA_W-1:0]  cfg_data,
	// sample stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [lfps_pkg::S_DATA_W-1:0]    s_tdata,  // sensor_bits[7:0], elapsed_ms[23:8]
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [lfps_pkg::M_DATA_W-1:0]    m_tdata   // pid_value[14:0], left_drive[30:15],
	                                                    // right_drive[46:31], zero[47]
);
	import lfps_pkg::*;

	localparam int SENS_USED = (SENSOR_COUNT < SENSOR_W) ? SENSOR_COUNT : SENSOR_W;
	localparam int SENS_HALF = SENSOR_COUNT / 2;

	// Configuration registers
	logic signed [GAIN_W-1:0]  prop_gain_q;
	logic signed [GAIN_W-1:0]  integ_gain_q;
	logic signed [GAIN_W-1:0]  deriv_gain_q;
	logic        [SPEED_W-1:0] speed_q;

	// Controller state and sequencer
	state_t                     state_q;
	logic signed [INTEG_W-1:0]  integ_q;
	logic signed [ERR_W-1:0]    prev_err_q;
	logic [DIV_CNT_W-1:0]       cnt_q;

	// Per-word working registers
	logic signed [ERR_W-1:0]    err_q;
	logic [ELAPSED_W-1:0]       dt_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic [DIV_STEPS-1:0]       num_q;
	logic [ELAPSED_W-1:0]       rem_q;
	logic                       neg_q;
	logic signed [PID_W-1:0]    pid_q;
	logic signed [DRIVE_W-1:0]  left_q;

	// Shared multiplier
	logic signed [GAIN_W-1:0]   mul_a;
	logic signed [GAIN_W-1:0]   mul_b;
	logic                       mul_en;
	logic signed [2*GAIN_W-1:0] prod_q;

	// Output register
	logic                       m_valid_q;
	logic signed [PID_W-1:0]    out_pid_q;
	logic signed [DRIVE_W-1:0]  out_left_q;
	logic signed [DRIVE_W-1:0]  out_right_q;

	// Combinational helpers
	logic signed [ERR_W-1:0]    err_in;
	logic signed [ERR_W:0]      delta;
	logic signed [INTEG_W:0]    integ_sum;
	logic signed [INTEG_W-1:0]  integ_sat;
	logic signed [15:0]         i_term;
	logic [ELAPSED_W:0]         rem_shift;
	logic [ELAPSED_W:0]         rem_diff;
	logic                       q_bit;
	logic signed [ACC_W-1:0]    d_term;
	logic signed [ACC_W-1:0]    total;
	logic signed [17:0]         total_c;
	logic signed [17:0]         mix_l;
	logic signed [17:0]         mix_r;
	logic signed [DRIVE_W-1:0]  drive_now;
	logic                       accept;
	logic                       out_free;

	// Scale a mix product back to Q2.14, truncating toward zero, and saturate
	function automatic logic signed [DRIVE_W-1:0] drive_of(input logic signed [2*GAIN_W-1:0] p);
		logic signed [2*GAIN_W-1:0] adj;
		logic signed [2*GAIN_W-1:0] q;
		adj = p + (p[2*GAIN_W-1] ? 64'(ONE_Q14 - 1) : 64'sd0);
		q = adj >>> FRAC_Q14;
		if (q > 64'(ONE_Q14)) begin
			return DRIVE_W'(ONE_Q14);
		end else if (q < -64'(ONE_Q14)) begin
			return DRIVE_W'(-ONE_Q14);
		end else begin
			return q[DRIVE_W-1:0];
		end
	endfunction

	// Mix term min(k*4p + 1, 1) in Q2.14
	function automatic logic signed [17:0] mix_of(input logic signed [PID_W-1:0] p,
	                                              input logic neg);
		logic signed [17:0] p4;
		logic signed [17:0] m;
		p4 = 18'(p) <<< 2;
		m = neg ? (18'(ONE_Q14) - p4) : (18'(ONE_Q14) + p4);
		return (m > 18'(ONE_Q14)) ? 18'(ONE_Q14) : m;
	endfunction

	assign cfg_ready = 1'b1;
	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	assign m_tvalid = m_valid_q;
	assign m_tdata = {1'b0, out_right_q, out_left_q, out_pid_q};

	// Line position from the sensor word; error is its negation
	always_comb begin
		logic signed [ERR_W-1:0] pos;
		pos = '0;
		for (int i = 0; i < SENS_USED; i++) begin
			if (s_tdata[i]) begin
				pos = pos + ERR_W'(i - SENS_HALF);
			end
		end
		err_in = -pos;
	end

	// Integral update with 32-bit saturation; err*dt product fits in 33 bits
	assign integ_sum = {integ_q[INTEG_W-1], integ_q} + prod_q[INTEG_W:0];
	always_comb begin
		if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
			integ_sat = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
			                               : {1'b0, {(INTEG_W-1){1'b1}}};
		end else begin
			integ_sat = integ_sum[INTEG_W-1:0];
		end
	end

	// I term clamp to +-0.2
	always_comb begin
		if (prod_q > 64'(I_LIMIT_Q16)) begin
			i_term = 16'(I_LIMIT_Q16);
		end else if (prod_q < -64'(I_LIMIT_Q16)) begin
			i_term = 16'(-I_LIMIT_Q16);
		end else begin
			i_term = prod_q[15:0];
		end
	end

	assign delta = {err_q[ERR_W-1], err_q} - {prev_err_q[ERR_W-1], prev_err_q};

	// One restoring-division step
	assign rem_shift = {rem_q, num_q[DIV_STEPS-1]};
	assign rem_diff = rem_shift - {1'b0, dt_q};
	assign q_bit = !rem_diff[ELAPSED_W];

	// Final PID sum, clamp to +-0.5, floor to Q2.14
	assign d_term = neg_q ? -ACC_W'({3'b000, num_q}) : ACC_W'({3'b000, num_q});
	assign total = acc_q + d_term;
	always_comb begin
		if (total > ACC_W'(PID_LIMIT_Q16)) begin
			total_c = 18'(PID_LIMIT_Q16);
		end else if (total < -ACC_W'(PID_LIMIT_Q16)) begin
			total_c = 18'(-PID_LIMIT_Q16);
		end else begin
			total_c = total[17:0];
		end
	end

	assign mix_l = mix_of(pid_q, 1'b1);
	assign mix_r = mix_of(pid_q, 1'b0);
	assign drive_now = drive_of(prod_q);

	// Operand select for the shared multiplier
	always_comb begin
		mul_en = 1'b1;
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MUL_P: begin
				mul_a = GAIN_W'(err_q);
				mul_b = prop_gain_q;
			end
			ST_MUL_E: begin
				mul_a = GAIN_W'(err_q);
				mul_b = GAIN_W'({1'b0, dt_q});
			end
			ST_MUL_I: begin
				mul_a = integ_gain_q;
				mul_b = integ_q;
			end
			ST_MUL_D: begin
				mul_a = deriv_gain_q;
				mul_b = GAIN_W'(delta);
			end
			ST_MIX_L: begin
				mul_a = GAIN_W'(mix_l);
				mul_b = GAIN_W'({1'b0, speed_q});
			end
			ST_MIX_R: begin
				mul_a = GAIN_W'(mix_r);
				mul_b = GAIN_W'({1'b0, speed_q});
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q <= '0;
			integ_gain_q <= '0;
			deriv_gain_q <= '0;
			speed_q <= SPEED_W'(ONE_Q14);
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_PROP_GAIN:  prop_gain_q <= cfg_data;
				REG_INTEG_GAIN: integ_gain_q <= cfg_data;
				REG_DERIV_GAIN: deriv_gain_q <= cfg_data;
				REG_SPEED_MULT: speed_q <= cfg_data[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	// Output valid: set when a result is loaded, cleared when it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Sequencer and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			integ_q <= '0;
			prev_err_q <= '0;
			cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (s_tdata[S_DATA_W-1:SENSOR_W] == '0) ? ST_MIX_L : ST_MUL_P;
					end
				end
				ST_MUL_P:    state_q <= ST_MUL_E;
				ST_MUL_E:    state_q <= ST_SUM_I;
				ST_SUM_I: begin
					integ_q <= integ_sat;
					state_q <= ST_MUL_I;
				end
				ST_MUL_I:    state_q <= ST_MUL_D;
				ST_MUL_D:    state_q <= ST_DIV_INIT;
				ST_DIV_INIT: begin
					prev_err_q <= err_q;
					cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_PID;
					end
				end
				ST_PID:      state_q <= ST_MIX_L;
				ST_MIX_L:    state_q <= ST_MIX_R;
				ST_MIX_R:    state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:     state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath words
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					err_q <= err_in;
					dt_q <= s_tdata[S_DATA_W-1:SENSOR_W];
					pid_q <= '0;
				end
			end
			ST_MUL_E: begin
				acc_q <= prod_q[ACC_W-1:0];
			end
			ST_MUL_D: begin
				acc_q <= acc_q + ACC_W'(i_term);
			end
			ST_DIV_INIT: begin
				neg_q <= prod_q[2*GAIN_W-1];
				num_q <= prod_q[2*GAIN_W-1] ? DIV_STEPS'(-prod_q) : prod_q[DIV_STEPS-1:0];
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= q_bit ? rem_diff[ELAPSED_W-1:0] : rem_shift[ELAPSED_W-1:0];
				num_q <= {num_q[DIV_STEPS-2:0], q_bit};
			end
			ST_PID: begin
				pid_q <= PID_W'(total_c >>> 2);
			end
			ST_MIX_R: begin
				left_q <= drive_now;
			end
			ST_DONE: begin
				if (out_free) begin
					out_pid_q <= pid_q;
					out_left_q <= left_q;
					out_right_q <= drive_now;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	// Steering value stays within +-0.5
	a_pid_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (out_pid_q >= -PID_W'(8192) && out_pid_q <= PID_W'(8192)))
		else $error("pid_value out of range");

	// Centered steering drives both wheels alike
	a_pid_zero_sym: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && out_pid_q == '0) |-> (out_left_q == out_right_q))
		else $error("drives differ at zero steering");

	// A word with no elapsed time leaves the integral alone
	a_zero_dt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tdata[S_DATA_W-1:SENSOR_W] == '0) |=> $stable(integ_q))
		else $error("integral changed on zero elapsed time");

	// Divider step count stays in range
	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q < DIV_CNT_W'(DIV_STEPS)))
		else $error("divider counter overrun");

	// A result appears only out of the final sequencer step
	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside final step");
`endif

endmodule

// ----- tb/tb_line_follow_pid_steering_top.sv -----
`timescale 1ns / 1ps

module tb_line_follow_pid_steering_top;
	import lfps_pkg::*;

	localparam int SENSORS = SENSOR_W;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int END_SETTLE = 60;
	localparam int RANDOM_PHASES = 7;
	localparam int PHASE_SAMPLES = 180;
	localparam int WINDUP_SAMPLES = 100;
	localparam int MAX_REPORTS = 20;
	localparam longint DRIFT_BOUND = 100000;
	localparam longint INTEG_MAX = 64'sd2147483647;
	localparam longint INTEG_MIN = -64'sd2147483648;

	typedef struct packed {
		logic [PID_W-1:0]   pid;
		logic [DRIVE_W-1:0] left;
		logic [DRIVE_W-1:0] right;
	} steer_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	reg_idx_t              cfg_index = REG_PROP_GAIN;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata = '0;    // sensor_bits[7:0], elapsed_ms[23:8]
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;         // pid_value[14:0], left_drive[30:15],
	                                        // right_drive[46:31], zero[47]

	// Predictor copy of the registers and PID state
	longint kp_q16 = 0;
	longint ki_q16 = 0;
	longint kd_q16 = 0;
	longint speed_q14 = ONE_Q14;
	longint integ_acc = 0;
	longint last_err = 0;

	steer_t steer_expect_q[$];
	int     fail_count = 0;
	int     samples_sent = 0;
	int     results_seen = 0;
	int     cfg_writes = 0;
	bit     idle_on = 1'b1;
	int     stall_left = 0;
	int     quiet_cycles = 0;

	line_follow_pid_steering_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic longint sat(longint v, longint lo, longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// error = -(sum of (index - count/2) over the lit sensors)
	function automatic longint line_error(logic [SENSOR_W-1:0] bits);
		longint pos;
		pos = 0;
		for (int k = 0; k < SENSORS; k++)
			if (bits[k]) pos += k - SENSORS / 2;
		return -pos;
	endfunction

	// min(mix, 1.0) scaled by the speed, truncated toward zero, then saturated
	function automatic longint drive_scale(longint mix);
		longint d;
		if (mix > ONE_Q14) mix = ONE_Q14;
		d = (mix * speed_q14) / ONE_Q14;
		return sat(d, -ONE_Q14, ONE_Q14);
	endfunction

	// One PID step; updates the predictor state like the block does
	function automatic steer_t predict_steering(logic [SENSOR_W-1:0] bits,
			logic [ELAPSED_W-1:0] dt);
		longint err, dt_l, p_t, i_t, d_t, total, pid_q14, left_d, right_d;
		steer_t r;
		pid_q14 = 0;
		dt_l = longint'(dt);
		if (dt_l != 0) begin
			err = line_error(bits);
			p_t = err * kp_q16;
			integ_acc = sat(integ_acc + err * dt_l, INTEG_MIN, INTEG_MAX);
			i_t = sat(ki_q16 * integ_acc, -I_LIMIT_Q16, I_LIMIT_Q16);
			d_t = (kd_q16 * (err - last_err)) / dt_l;
			last_err = sat(err, -128, 127);
			total = sat(p_t + i_t + d_t, -PID_LIMIT_Q16, PID_LIMIT_Q16);
			// Q.16 to Q2.14, rounding toward minus infinity
			pid_q14 = ((total + PID_LIMIT_Q16) >>> 2) - (PID_LIMIT_Q16 >>> 2);
		end
		left_d = drive_scale(-4 * pid_q14 + ONE_Q14);
		right_d = drive_scale(4 * pid_q14 + ONE_Q14);
		r.pid = pid_q14[PID_W-1:0];
		r.left = left_d[DRIVE_W-1:0];
		r.right = right_d[DRIVE_W-1:0];
		return r;
	endfunction

	function automatic void apply_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_PROP_GAIN:  kp_q16 = longint'(signed'(val));
			REG_INTEG_GAIN: ki_q16 = longint'(signed'(val));
			REG_DERIV_GAIN: kd_q16 = longint'(signed'(val));
			REG_SPEED_MULT: speed_q14 = longint'(val[SPEED_W-1:0]);
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [M_DATA_W-1:0] got,
			input logic [M_DATA_W-1:0] want);
		if (fail_count < MAX_REPORTS)
			$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what,
				got, want);
		fail_count++;
	endtask

	// Result checker and receiver with random stall bursts
	always @(posedge clk) begin
		steer_t got, want;
		if (m_tvalid && m_tready) begin
			got.pid = m_tdata[PID_W-1:0];
			got.left = m_tdata[PID_W +: DRIVE_W];
			got.right = m_tdata[PID_W+DRIVE_W +: DRIVE_W];
			results_seen++;
			if (steer_expect_q.size() == 0) begin
				report_mismatch("word with nothing pending", m_tdata, '0);
			end else begin
				want = steer_expect_q.pop_front();
				if (got.pid !== want.pid)
					report_mismatch("pid_value", M_DATA_W'(got.pid), M_DATA_W'(want.pid));
				if (got.left !== want.left)
					report_mismatch("left_drive", M_DATA_W'(got.left), M_DATA_W'(want.left));
				if (got.right !== want.right)
					report_mismatch("right_drive", M_DATA_W'(got.right),
						M_DATA_W'(want.right));
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 8) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog: too long without any handshake ends the run
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] watchdog: no handshake for %0d cycles", $realtime, quiet_cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Send one sample word, optionally after an idle burst
	task automatic send_sample(input logic [SENSOR_W-1:0] bits,
			input logic [ELAPSED_W-1:0] dt);
		int gap;
		if (idle_on && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 8);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {dt, bits};
		do @(posedge clk); while (!s_tready);
		steer_expect_q.push_back(predict_steering(bits, dt));
		samples_sent++;
	endtask

	// Stop sending and wait until every expected word has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (steer_expect_q.size() != 0);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, val);
		cfg_writes++;
	endtask

	task automatic set_gains(input logic [31:0] kp, input logic [31:0] ki,
			input logic [31:0] kd, input logic [31:0] speed);
		drain_results();
		write_reg(REG_PROP_GAIN, kp);
		write_reg(REG_INTEG_GAIN, ki);
		write_reg(REG_DERIV_GAIN, kd);
		write_reg(REG_SPEED_MULT, speed);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_gain();
		case ($urandom_range(0, 4))
			0, 1: return 32'($urandom_range(0, 8192)) - 32'd4096;
			2: return 32'($urandom_range(0, 140000)) - 32'd70000;
			3: return $urandom;
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'hFFFF_FFFF;
					default: return 32'h0;
				endcase
			end
		endcase
	endfunction

	function automatic logic [31:0] rand_speed();
		case ($urandom_range(0, 5))
			0: return 32'(ONE_Q14);
			1: return 32'h0;
			2: return 32'($urandom_range(ONE_Q14 + 1, 32767));
			default: return 32'($urandom_range(1, ONE_Q14 - 1));
		endcase
	endfunction

	// A line seen by one to three adjacent sensors
	function automatic logic [SENSOR_W-1:0] line_pattern();
		int c, w;
		logic [SENSOR_W-1:0] b;
		c = $urandom_range(0, SENSORS - 1);
		w = $urandom_range(1, 3);
		b = '0;
		for (int k = 0; k < w; k++)
			if (c + k < SENSORS) b[c+k] = 1'b1;
		return b;
	endfunction

	task automatic send_random_sample();
		logic [SENSOR_W-1:0] bits;
		logic [ELAPSED_W-1:0] dt;
		int tries;
		if ($urandom_range(0, 3) == 0) bits = 8'($urandom_range(0, 255));
		else bits = line_pattern();
		// steer the line back when the running sum drifts, so the I term stays in reach
		tries = 0;
		while (tries < 8 && ((integ_acc > DRIFT_BOUND && line_error(bits) > 0) ||
				(integ_acc < -DRIFT_BOUND && line_error(bits) < 0))) begin
			bits = line_pattern();
			tries++;
		end
		case ($urandom_range(0, 19))
			0, 1: dt = '0;
			2, 3, 4, 5, 6, 7, 8, 9, 10, 11: dt = 16'($urandom_range(1, 50));
			12, 13, 14, 15, 16: dt = 16'($urandom_range(1, 1000));
			default: dt = 16'($urandom_range(0, 65535));
		endcase
		send_sample(bits, dt);
	endtask

	// Zero gains after reset: steering stays at 0, drives at full speed
	task automatic test_reset_values();
		send_sample(8'h00, 16'h0000);
		send_sample(8'hFF, 16'hFFFF);
		send_sample(8'h0F, 16'h0001);
	endtask

	// Field extremes, zero elapsed time, gain and speed extremes
	task automatic test_directed_cases();
		set_gains(32'h0000_0CCD, 32'h0000_0100, 32'h0001_0000, 32'(ONE_Q14));
		send_sample(8'h01, 16'h0001);
		send_sample(8'h80, 16'h0001);
		send_sample(8'h18, 16'h000A);
		send_sample(8'h00, 16'h0064);
		send_sample(8'hFF, 16'hFFFF);
		send_sample(8'h0F, 16'h0000);
		send_sample(8'hF0, 16'h8000);
		send_sample(8'hAA, 16'h5555);
		send_sample(8'h55, 16'hAAAA);
		// speed above 1.0 drives the saturation of both drives
		set_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_7FFF);
		send_sample(8'h01, 16'h0001);
		send_sample(8'h80, 16'h0001);
		send_sample(8'h0F, 16'hFFFF);
		send_sample(8'h00, 16'h0007);
		set_gains(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
		send_sample(8'hF0, 16'h0001);
		send_sample(8'h0F, 16'h0003);
		send_sample(8'h00, 16'h0000);
	endtask

	// Random samples over several random register settings
	task automatic test_random_settings();
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			set_gains(rand_gain(), rand_gain(), rand_gain(), rand_speed());
			for (int n = 0; n < PHASE_SAMPLES; n++) begin
				if (ph == RANDOM_PHASES - 1) idle_on = 1'b0;
				else if (n % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
				send_random_sample();
			end
		end
	endtask

	// Drive the running sum far up with the largest steps, then pull it back
	task automatic test_integral_windup();
		int guard;
		set_gains(32'h0, 32'h1, 32'h0, 32'(ONE_Q14));
		idle_on = 1'b0;
		guard = 0;
		while (integ_acc < INTEG_MAX && guard < WINDUP_SAMPLES) begin
			send_sample(8'h0F, 16'hFFFF);
			guard++;
		end
		send_sample(8'h0F, 16'hFFFF);
		send_sample(8'h0F, 16'hFFFF);
		send_sample(8'hF0, 16'h0001);
		send_sample(8'h00, 16'h0005);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_directed_cases();
		test_random_settings();
		test_integral_windup();
		drain_results();
		repeat (END_SETTLE) @(posedge clk);
		$display("Summary: %0d samples, %0d words checked, %0d register writes, %0d mismatches",
			samples_sent, results_seen, cfg_writes, fail_count);
		$display("Summary: corner samples, random gains and speeds, integral build-up");
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/lfps_pkg.sv
rtl/core/line_follow_pid_steering_top.sv
tb/tb_line_follow_pid_steering_top.sv
